// ----- sv/sflc_pkg.sv -----
package sflc_pkg;

  localparam int BIN_COUNT_DEF   = 256;
  localparam int ALIGN_BYTES_DEF = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int REQ_W     = 2;
  localparam int SIZE_W    = 16;
  localparam int HANDLE_W  = 16;
  localparam int STATUS_W  = 3;
  localparam int OSIZE_W   = 9;
  localparam int TOTAL_W   = 24;
  localparam int MIN_W     = 9;
  localparam int META_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CACHED      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DRAINED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DRAIN_EMPTY = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_META_CHARGE  = 2'd2;

  localparam logic [TOTAL_W-1:0] LIMIT_RST = TOTAL_W'(1024 * 1024);
  localparam logic [MIN_W-1:0]   MIN_RST   = 9'd8;
  localparam logic [META_W-1:0]  META_RST  = 7'd16;

  typedef struct packed {
    logic clr;
    logic accept;
    logic rd;
    logic advance;
    logic res_none;
    logic rd_link;
    logic put;
    logic pop;
    logic load_out;
  } sflc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic early;
    logic is_put;
    logic is_drain;
    logic head_zero;
    logic bin_last;
    logic out_free;
  } sflc_sts_t;

endpackage

// ----- sv/sflc_ctrl.sv -----
module sflc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sflc_pkg::sflc_sts_t sts,
  output sflc_pkg::sflc_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_POST  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.early ? S_POST : S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        priority if (sts.is_put) begin
          state_next = S_PUT;
        end else if (sts.head_zero && sts.is_drain && !sts.bin_last) begin
          cmd.advance = 1'b1;
          state_next  = S_RD;
        end else if (sts.head_zero) begin
          cmd.res_none = 1'b1;
          state_next   = S_POST;
        end else begin
          cmd.rd_link = 1'b1;
          state_next  = S_LINK;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_POST;
      end
      S_LINK: begin
        cmd.pop    = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr, cmd.accept, cmd.rd, cmd.advance, cmd.res_none,
              cmd.rd_link, cmd.put, cmd.pop, cmd.load_out}))
    else $error("more than one command at once");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending result");
`endif

endmodule

// ----- sv/sflc_dp.sv -----
module sflc_dp #(
  parameter int BIN_COUNT   = sflc_pkg::BIN_COUNT_DEF,
  parameter int ALIGN_BYTES = sflc_pkg::ALIGN_BYTES_DEF,
  parameter int HANDLE_BITS = sflc_pkg::HANDLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sflc_pkg::sflc_cmd_t                   cmd,
  output sflc_pkg::sflc_sts_t                   sts,
  input  logic                                  cfg_valid,
  input  logic [sflc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sflc_pkg::TOTAL_W-1:0]          cfg_data,
  input  logic [sflc_pkg::REQ_W-1:0]            req_type,
  input  logic [sflc_pkg::SIZE_W-1:0]           block_size,
  input  logic [sflc_pkg::HANDLE_W-1:0]         block_handle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sflc_pkg::STATUS_W-1:0]         status,
  output logic [sflc_pkg::HANDLE_W-1:0]         out_handle,
  output logic [sflc_pkg::OSIZE_W-1:0]          out_size,
  output logic [sflc_pkg::TOTAL_W-1:0]          charge_level
);

  localparam int BW    = $clog2(BIN_COUNT);
  localparam int SW    = BW + 1;
  localparam int HW    = HANDLE_BITS;
  localparam int XW    = $clog2(BIN_COUNT + 128 + ALIGN_BYTES) + 1;
  localparam int SH    = XW + 7;
  localparam int RW    = SH + 1;
  localparam int PW    = XW + RW;
  localparam int CW    = XW + 7;
  localparam int RECIP = ((1 << SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int TW    = sflc_pkg::TOTAL_W;

  logic [TW-1:0]                   cfg_limit;
  logic [sflc_pkg::MIN_W-1:0]      cfg_min;
  logic [sflc_pkg::META_W-1:0]     cfg_meta;

  logic [HW-1:0] head_mem [BIN_COUNT];
  logic [HW-1:0] link_mem [2**HW];

  logic [BW-1:0]                   clr_cnt;
  logic [SW-1:0]                   scan_start;
  logic [TW-1:0]                   total;
  logic [sflc_pkg::REQ_W-1:0]      req_r;
  logic [BW-1:0]                   cur_bin;
  logic [HW-1:0]                   handle_r;
  logic [HW-1:0]                   head_q;
  logic [HW-1:0]                   link_q;
  logic [XW-1:0]                   q_r;
  logic [CW-1:0]                   charge_r;
  logic [sflc_pkg::STATUS_W-1:0]   res_status;
  logic [HW-1:0]                   res_handle;
  logic [sflc_pkg::OSIZE_W-1:0]    res_size;

  logic [HW-1:0]                   in_handle;
  logic                            size_zero;
  logic                            cacheable;
  logic                            scan_empty;
  logic                            early;
  logic [sflc_pkg::STATUS_W-1:0]   early_status;
  logic [XW-1:0]                   chg_y;
  logic [PW-1:0]                   prod;
  logic [TW:0]                     put_sum;
  logic                            put_ok;
  logic                            head_we;
  logic [BW-1:0]                   head_waddr;
  logic [HW-1:0]                   head_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_limit <= sflc_pkg::LIMIT_RST;
      cfg_min   <= sflc_pkg::MIN_RST;
      cfg_meta  <= sflc_pkg::META_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sflc_pkg::CFG_CHARGE_LIMIT: cfg_limit <= cfg_data;
        sflc_pkg::CFG_MIN_SIZE:     cfg_min   <= cfg_data[sflc_pkg::MIN_W-1:0];
        sflc_pkg::CFG_META_CHARGE:  cfg_meta  <= cfg_data[sflc_pkg::META_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_handle  = HW'(block_handle);
  assign size_zero  = (block_size == '0);
  assign cacheable  = (block_size >= sflc_pkg::SIZE_W'(cfg_min))
                   && ({1'b0, block_size} <= (sflc_pkg::SIZE_W + 1)'(BIN_COUNT));
  assign scan_empty = (scan_start == SW'(BIN_COUNT));

  always_comb begin
    early        = 1'b1;
    early_status = sflc_pkg::ST_REFUSED;
    unique case (req_type)
      sflc_pkg::REQ_GET: begin
        priority if (size_zero) begin
          early_status = sflc_pkg::ST_BAD_SIZE;
        end else if (!cacheable) begin
          early_status = sflc_pkg::ST_MISS;
        end else begin
          early = 1'b0;
        end
      end
      sflc_pkg::REQ_PUT: begin
        priority if (size_zero) begin
          early_status = sflc_pkg::ST_BAD_SIZE;
        end else if (!cacheable || in_handle == '0) begin
          early_status = sflc_pkg::ST_REFUSED;
        end else begin
          early = 1'b0;
        end
      end
      sflc_pkg::REQ_DRAIN: begin
        early_status = sflc_pkg::ST_DRAIN_EMPTY;
        early        = scan_empty;
      end
      default: begin
        early_status = sflc_pkg::ST_REFUSED;
      end
    endcase
  end

  assign chg_y = XW'(cur_bin) + XW'(1) + XW'(cfg_meta) + XW'(ALIGN_BYTES - 1);
  assign prod  = PW'(chg_y) * PW'(RECIP);

  always_ff @(posedge clk) begin
    q_r      <= XW'(prod >> SH);
    charge_r <= CW'(q_r) * CW'(ALIGN_BYTES);
  end

  assign put_sum = {1'b0, total} + (TW + 1)'(charge_r);
  assign put_ok  = (put_sum <= {1'b0, cfg_limit});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= req_type;
      handle_r <= in_handle;
      cur_bin  <= (req_type == sflc_pkg::REQ_DRAIN) ? scan_start[BW-1:0]
                                                    : BW'(block_size - 16'd1);
    end else if (cmd.advance) begin
      cur_bin <= cur_bin + BW'(1);
    end
  end

  assign head_we    = cmd.clr || (cmd.put && put_ok) || cmd.pop;
  assign head_waddr = cmd.clr ? clr_cnt : cur_bin;
  assign head_wdata = cmd.clr ? '0 : (cmd.put ? handle_r : link_q);

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (cmd.rd) begin
      head_q <= head_mem[cur_bin];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put && put_ok) begin
      link_mem[handle_r] <= head_q;
    end
    if (cmd.rd_link) begin
      link_q <= link_mem[head_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      scan_start <= SW'(BIN_COUNT);
    end else begin
      if (cmd.put && put_ok) begin
        total <= put_sum[TW-1:0];
        if ({1'b0, cur_bin} < scan_start) begin
          scan_start <= {1'b0, cur_bin};
        end
      end
      if (cmd.pop) begin
        total <= (total > TW'(charge_r)) ? total - TW'(charge_r) : '0;
        if (req_r == sflc_pkg::REQ_DRAIN) begin
          scan_start <= {1'b0, cur_bin};
        end
      end
      if (cmd.res_none && req_r == sflc_pkg::REQ_DRAIN) begin
        scan_start <= SW'(BIN_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.accept) begin
      res_status <= early_status;
      res_handle <= '0;
      res_size   <= '0;
    end else if (cmd.res_none) begin
      res_status <= (req_r == sflc_pkg::REQ_DRAIN) ? sflc_pkg::ST_DRAIN_EMPTY
                                                   : sflc_pkg::ST_MISS;
    end else if (cmd.put) begin
      res_status <= put_ok ? sflc_pkg::ST_CACHED : sflc_pkg::ST_REFUSED;
    end else if (cmd.pop) begin
      res_handle <= head_q;
      if (req_r == sflc_pkg::REQ_DRAIN) begin
        res_status <= sflc_pkg::ST_DRAINED;
        res_size   <= sflc_pkg::OSIZE_W'(SW'(cur_bin) + SW'(1));
      end else begin
        res_status <= sflc_pkg::ST_HIT;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      out_handle   <= sflc_pkg::HANDLE_W'(res_handle);
      out_size     <= res_size;
      charge_level <= total;
    end
  end

  assign sts.clr_last  = (clr_cnt == BW'(BIN_COUNT - 1));
  assign sts.early     = early;
  assign sts.is_put    = (req_r == sflc_pkg::REQ_PUT);
  assign sts.is_drain  = (req_r == sflc_pkg::REQ_DRAIN);
  assign sts.head_zero = (head_q == '0);
  assign sts.bin_last  = (cur_bin == BW'(BIN_COUNT - 1));
  assign sts.out_free  = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_start <= SW'(BIN_COUNT))
    else $error("scan start beyond last bin");

  a_put_budget: assert property (@(posedge clk) disable iff (rst)
    cmd.put && put_ok |=> total <= $past(cfg_limit))
    else $error("cached charge above limit after put");

  a_pop_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> head_q != '0)
    else $error("pop from an empty list");
`endif

endmodule

// ----- sv/size_class_free_list_cache.sv -----
// After acceptance a put goes S_RD, S_HEAD, S_PUT, S_POST; a get hit S_RD, S_HEAD, S_LINK,
// S_POST; a get on an empty list S_RD, S_HEAD, S_POST; a request with no list access (bad
// size, miss by size, refused, empty cache) goes straight to S_POST. A drain repeats S_RD
// and S_HEAD per empty size class skipped. A new request is taken only once the last
// result is loaded; S_POST waits while a result is pending. Reset: synchronous; then the
// head memory is cleared with in_ready low. Configuration writes are taken at any time.
module size_class_free_list_cache #(
  parameter int BIN_COUNT   = sflc_pkg::BIN_COUNT_DEF,
  parameter int ALIGN_BYTES = sflc_pkg::ALIGN_BYTES_DEF,
  parameter int HANDLE_BITS = sflc_pkg::HANDLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sflc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sflc_pkg::TOTAL_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sflc_pkg::REQ_W-1:0]        req_type,
  input  logic [sflc_pkg::SIZE_W-1:0]       block_size,
  input  logic [sflc_pkg::HANDLE_W-1:0]     block_handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sflc_pkg::STATUS_W-1:0]     status,
  output logic [sflc_pkg::HANDLE_W-1:0]     out_handle,
  output logic [sflc_pkg::OSIZE_W-1:0]      out_size,
  output logic [sflc_pkg::TOTAL_W-1:0]      charge_level
);

  sflc_pkg::sflc_cmd_t cmd;
  sflc_pkg::sflc_sts_t sts;

  assign cfg_ready = 1'b1;

  sflc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sflc_dp #(
    .BIN_COUNT   (BIN_COUNT),
    .ALIGN_BYTES (ALIGN_BYTES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .block_size   (block_size),
    .block_handle (block_handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_handle   (out_handle),
    .out_size     (out_size),
    .charge_level (charge_level)
  );

endmodule
